// File: src/bitmap_run_allocator_defines.svh
// Assertion macros for the bitmap run allocator
`ifndef BITMAP_RUN_ALLOCATOR_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_DEFINES_SVH

// immediate implication checked every cycle outside reset
`define BRA_ASSERT_IMP(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: label failed");

// next-cycle implication checked outside reset
`define BRA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: label failed");

`endif

// File: src/bra_pkg.sv
package bra_pkg;

   localparam int MaxBits   = 1024;
   localparam int WordBits  = 32;
   localparam int Words     = (MaxBits + WordBits - 1) / WordBits;
   localparam int AddrW     = $clog2(Words);
   localparam int BitW      = $clog2(WordBits);
   localparam int PosW      = 11;
   localparam int CntW      = 11;

   typedef enum logic [2:0] {
      KIND_WRITE   = 3'd0,
      KIND_FLIP    = 3'd1,
      KIND_TEST    = 3'd2,
      KIND_COUNT   = 3'd3,
      KIND_CONTAIN = 3'd4,
      KIND_SCAN    = 3'd5,
      KIND_SCANFLP = 3'd6,
      KIND_BAD     = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0]      kind;
      logic [PosW-1:0] position;
      logic [PosW-1:0] length;
      logic            bit_value;
   } req_type;

   typedef struct packed {
      logic [CntW-1:0] number;
      logic            truth;
      logic            fault;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_DECODE,    // bounds checks on the captured request
      ST_RD,        // issue read of the word holding the current bit
      ST_WAIT,      // read data returns, bit processed and, for writes and flips, written back
      ST_FLIP_RD,   // second pass for scan-and-flip
      ST_FLIP_WAIT
   } state_type;

   // memory port bundle between controller and store
   typedef struct packed {
      logic             re;
      logic             we;
      logic [AddrW-1:0] addr;
      logic [WordBits-1:0] wdata;
   } mem_cmd_type;

endpackage

// File: src/bitmap_run_allocator.sv
// Channel   | Ports                         | Handshake
// request   | req_payload                   | start & !busy
// response  | rsp_payload                   | rsp_valid, one cycle
// config    | csr_we, csr_wdata             | csr_we
// Reset is synchronous; after it a clearing pass writes all 32 store words while busy
// is high. Each request passes through a decode state; faults, zero lengths, oversized
// scans and scans with no bits left respond from there. Each walked bit passes through
// a read state and a wait state in which it is processed and, for writes and flips,
// written back. Scans walk from position to the end of the run or the size in use;
// scan-and-flip then rewrites the run bit by bit. The receiver cannot stall.
module bitmap_run_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  bra_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   output bra_pkg::rsp_type               rsp_payload,
   input  logic                           csr_we,
   input  logic [10:0]                    csr_wdata
);
   import bra_pkg::*;
   `include "bitmap_run_allocator_defines.svh"

   state_type           state_ff, state_in;
   req_type             req_ff, req_in;
   logic [10:0]         size_ff, size_in;
   logic [PosW:0]       idx_ff, idx_in;       // bit being walked
   logic [CntW:0]       cnt_ff, cnt_in;       // bits done, or run length in a scan
   logic [CntW-1:0]     acc_ff, acc_in;       // matching bits so far
   logic [PosW-1:0]     found_ff, found_in;   // start of the run found
   logic                valid_ff, valid_in;
   rsp_type             rsp_ff, rsp_in;
   mem_cmd_type         cmd;
   logic [WordBits-1:0] rdata;
   logic [10:0]         usize;
   logic [PosW:0]       endp;
   logic                rng_ok;
   logic [BitW-1:0]     boff;
   logic                rbit, match;
   logic [CntW:0]       cnt_next;
   logic [PosW:0]       run_start;
   logic                dec_done;
   rsp_type             dec_rsp;
   logic                step_last, step_flip, step_we, step_wbit;
   rsp_type             step_rsp;
   logic [WordBits-1:0] wmod;

   bra_store u_store (.clock(clock), .cmd(cmd), .rdata(rdata));

   assign usize     = (size_ff > 11'(MaxBits)) ? 11'(MaxBits) : size_ff;
   assign endp      = {1'b0, req_ff.position} + {1'b0, req_ff.length};
   assign rng_ok    = (req_ff.position <= usize) && (endp <= {1'b0, usize});
   assign boff      = idx_ff[BitW-1:0];
   assign rbit      = rdata[boff];
   assign match     = (rbit == req_ff.bit_value);
   assign cnt_next  = cnt_ff + 1'b1;
   assign run_start = idx_ff + 1'b1 - {1'b0, req_ff.length};

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         size_ff  <= 11'(MaxBits);
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         req_ff   <= '0;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         found_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         req_ff   <= req_in;
         cnt_ff   <= cnt_in;
         acc_ff   <= acc_in;
         found_ff <= found_in;
         rsp_ff   <= rsp_in;
      end
   end

   // decode: requests answered without touching the store
   always_comb begin
      dec_done = 1'b0;
      dec_rsp  = '0;
      unique case (kind_type'(req_ff.kind))
         KIND_WRITE, KIND_COUNT, KIND_CONTAIN: begin
            priority if (!rng_ok) begin
               dec_rsp.fault = 1'b1;
               dec_done      = 1'b1;
            end else if (req_ff.length == '0) begin
               dec_done = 1'b1;
            end else begin
               dec_done = 1'b0;
            end
         end
         KIND_FLIP, KIND_TEST: begin
            if (req_ff.position >= usize) begin
               dec_rsp.fault = 1'b1;
               dec_done      = 1'b1;
            end
         end
         KIND_SCAN, KIND_SCANFLP: begin
            priority if (req_ff.position > usize) begin
               dec_rsp.fault = 1'b1;
               dec_done      = 1'b1;
            end else if (req_ff.length > usize) begin
               dec_done = 1'b1;
            end else if (req_ff.length == '0) begin
               dec_rsp.number = req_ff.position;
               dec_rsp.truth  = 1'b1;
               dec_done       = 1'b1;
            end else if (req_ff.position >= usize) begin
               // no bits left to scan
               dec_done = 1'b1;
            end else begin
               dec_done = 1'b0;
            end
         end
         default: begin
            dec_rsp.fault = 1'b1;
            dec_done      = 1'b1;
         end
      endcase
   end

   // per-bit step once the word is back from the store
   always_comb begin
      step_last = 1'b0;
      step_flip = 1'b0;
      step_we   = 1'b0;
      step_wbit = rbit;
      step_rsp  = '0;
      if (state_ff == ST_FLIP_WAIT) begin
         // rewrite one bit of the run found
         step_we         = 1'b1;
         step_wbit       = ~req_ff.bit_value;
         step_last       = (cnt_next == {1'b0, req_ff.length});
         step_rsp.number = found_ff;
         step_rsp.truth  = 1'b1;
      end else begin
         unique case (kind_type'(req_ff.kind))
            KIND_WRITE: begin
               step_we   = 1'b1;
               step_wbit = req_ff.bit_value;
               step_last = (cnt_next == {1'b0, req_ff.length});
            end
            KIND_FLIP: begin
               step_we   = 1'b1;
               step_wbit = ~rbit;
               step_last = 1'b1;
            end
            KIND_TEST: begin
               step_rsp.truth = rbit;
               step_last      = 1'b1;
            end
            KIND_COUNT, KIND_CONTAIN: begin
               step_last = (cnt_next == {1'b0, req_ff.length});
               if (req_ff.kind == KIND_COUNT)
                  step_rsp.number = acc_ff + CntW'(match);
               else
                  step_rsp.truth = (acc_ff != '0) || match;
            end
            KIND_SCAN, KIND_SCANFLP: begin
               priority if (match && (cnt_next == {1'b0, req_ff.length})) begin
                  step_rsp.number = run_start[PosW-1:0];
                  step_rsp.truth  = 1'b1;
                  if (req_ff.kind == KIND_SCANFLP) step_flip = 1'b1;
                  else step_last = 1'b1;
               end else if ((idx_ff + 1'b1) >= {1'b0, usize}) begin
                  // end of bitmap, no run
                  step_last = 1'b1;
               end else begin
                  step_last = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // write-back word
   always_comb begin
      wmod       = rdata;
      wmod[boff] = step_wbit;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:     if (idx_ff == (PosW+1)'(Words-1)) state_in = ST_IDLE;
         ST_IDLE:      if (start) state_in = ST_DECODE;
         ST_DECODE:    state_in = dec_done ? ST_IDLE : ST_RD;
         ST_RD:        state_in = ST_WAIT;
         ST_WAIT: begin
            priority if (step_last) state_in = ST_IDLE;
            else if (step_flip)     state_in = ST_FLIP_RD;
            else                    state_in = ST_RD;
         end
         ST_FLIP_RD:   state_in = ST_FLIP_WAIT;
         ST_FLIP_WAIT: state_in = step_last ? ST_IDLE : ST_FLIP_RD;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in   = req_ff;
      size_in  = csr_we ? csr_wdata : size_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      found_in = found_ff;
      rsp_in   = rsp_ff;
      valid_in = 1'b0;
      cmd      = '0;
      busy     = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.we   = 1'b1;
            cmd.addr = idx_ff[AddrW-1:0];
            idx_in   = idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (start) begin
               req_in   = req_payload;
               idx_in   = {1'b0, req_payload.position};
               cnt_in   = '0;
               acc_in   = '0;
               found_in = '0;
            end
         end
         ST_DECODE: begin
            if (dec_done) begin
               rsp_in   = dec_rsp;
               valid_in = 1'b1;
            end
         end
         ST_RD, ST_FLIP_RD: begin
            cmd.re   = 1'b1;
            cmd.addr = idx_ff[BitW+AddrW-1:BitW];
         end
         ST_WAIT, ST_FLIP_WAIT: begin
            cmd.addr  = idx_ff[BitW+AddrW-1:BitW];
            cmd.we    = step_we;
            cmd.wdata = wmod;
            // scans track the current run length, others the bits done
            if (state_ff == ST_WAIT &&
                (req_ff.kind == KIND_SCAN || req_ff.kind == KIND_SCANFLP))
               cnt_in = match ? cnt_next : '0;
            else
               cnt_in = cnt_next;
            acc_in = acc_ff + CntW'(match);
            idx_in = idx_ff + 1'b1;
            if (step_flip) begin
               found_in = run_start[PosW-1:0];
               idx_in   = run_start;
               cnt_in   = '0;
            end
            if (step_last) begin
               rsp_in   = step_rsp;
               valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = rsp_ff;

   `BRA_ASSERT_IMP(a_no_start_busy, clock, reset, rsp_valid, state_ff == ST_IDLE)
   `BRA_ASSERT_NEXT(a_resp_one, clock, reset, rsp_valid, !rsp_valid)
   `BRA_ASSERT_IMP(a_fault_clean, clock, reset, rsp_valid && rsp_payload.fault,
                   rsp_payload.number == '0 && !rsp_payload.truth)
   `BRA_ASSERT_IMP(a_walk_range, clock, reset, state_ff == ST_WAIT || state_ff == ST_FLIP_WAIT,
                   idx_ff < (PosW+1)'(usize))
endmodule

// File: src/bra_store.sv
module bra_store (
   input  logic                 clock,
   input  bra_pkg::mem_cmd_type cmd,
   output logic [bra_pkg::WordBits-1:0] rdata
);
   import bra_pkg::*;

   logic [WordBits-1:0] mem [Words];

   // single-port synchronous RAM, registered read
   always_ff @(posedge clock) begin
      if (cmd.we) mem[cmd.addr] <= cmd.wdata;
      if (cmd.re) rdata <= mem[cmd.addr];
   end
endmodule
